// ===== design/skt_pkg.sv =====
// Shared constants, types and codes for the sorted key table.
package skt_pkg;

    localparam int DEPTH   = 16;
    localparam int KEY_W   = 31;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int COUNT_W = 5;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_DELETE = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } t_cell_op;

    // Broadcast from the top level to every cell
    typedef struct packed {
        t_cell_op         op;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

    // What a cell shows to its neighbours and to the top level
    typedef struct packed {
        logic             valid;
        logic             lt;
        logic             eq;
        logic [KEY_W-1:0] key;
    } t_cell_state;

endpackage

// ===== design/skt_req_if.sv =====
// Request channel: valid/ready handshake carrying request type and key.
interface skt_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [skt_pkg::KEY_W-1:0]  key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

// ===== design/skt_rsp_if.sv =====
// Response channel: valid/ready handshake carrying status and entry count.
interface skt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [skt_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ===== design/skt_cell.sv =====
// One slot of the sorted chain: holds a key and its valid bit, shifts with its neighbours.
module skt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  skt_pkg::t_cell_ctl   i_ctl,
    input  skt_pkg::t_cell_state i_prev,
    input  skt_pkg::t_cell_state i_next,
    output skt_pkg::t_cell_state o_state
);

    logic                      r_valid;
    logic [skt_pkg::KEY_W-1:0] r_key;
    logic                      n_valid;
    logic [skt_pkg::KEY_W-1:0] n_key;
    logic                      w_lt;
    logic                      w_eq;

    assign w_lt = r_valid && (r_key < i_ctl.key);
    assign w_eq = r_valid && (r_key == i_ctl.key);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        case (i_ctl.op)
            skt_pkg::OP_INSERT: begin
                // Cells at or behind the insertion point move down one slot
                if (!w_lt) begin
                    n_key   = i_prev.lt ? i_ctl.key : i_prev.key;
                    n_valid = r_valid | i_prev.valid;
                end
            end
            skt_pkg::OP_DELETE: begin
                // Cells from the first match onwards pull from behind
                if (!w_lt) begin
                    n_key   = i_next.key;
                    n_valid = i_next.valid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_state.valid = r_valid;
    assign o_state.lt    = w_lt;
    assign o_state.eq    = w_eq;
    assign o_state.key   = r_key;

endmodule

// ===== design/sorted_key_table_insert_delete.sv =====
// Top level of the sorted key table: cell chain, entry counter and response register.
//
//   channel   direction   payload                 handshake
//   i_req     in          req_type, key           valid / ready
//   o_rsp     out         status, entry_count     valid / ready
//
// One transaction per cycle while the response is not stalled: every cell compares its key
// with the request key in parallel and the whole chain shifts in the same cycle.
// The response is registered; a new request is taken while the response
// register is empty or is being drained in the same cycle.
// Reset clears all valid bits, the counter and the response valid.
// A stalled response holds the request side off; no transaction is dropped.
module sorted_key_table_insert_delete (
    input  logic           i_clk,
    input  logic           i_rst_n,
    skt_req_if.sink        i_req,
    skt_rsp_if.source      o_rsp
);

    skt_pkg::t_cell_ctl                      w_ctl;
    skt_pkg::t_cell_state [skt_pkg::DEPTH-1:0] w_state;
    skt_pkg::t_cell_state [skt_pkg::DEPTH-1:0] w_prev;
    skt_pkg::t_cell_state [skt_pkg::DEPTH-1:0] w_next;
    logic [skt_pkg::DEPTH-1:0]               w_eq;

    logic [skt_pkg::CNT_W-1:0]   r_count;
    logic [skt_pkg::CNT_W-1:0]   n_count;
    logic                        r_out_valid;
    logic                        n_out_valid;
    skt_pkg::t_status            r_status;
    skt_pkg::t_status            n_status;
    logic [skt_pkg::COUNT_W-1:0] r_entry_count;

    logic w_accept;
    logic w_full;
    logic w_empty;
    logic w_found;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == skt_pkg::CNT_W'(skt_pkg::DEPTH));
    assign w_empty     = (r_count == '0);

    for (genvar g = 0; g < skt_pkg::DEPTH; g++) begin : g_eq
        assign w_eq[g] = w_state[g].eq;
    end
    assign w_found = |w_eq;

    // Decide the operation, the status and the new entry count
    always_comb begin
        w_ctl.op  = skt_pkg::OP_HOLD;
        w_ctl.key = i_req.key;
        n_status  = r_status;
        n_count   = r_count;
        if (w_accept) begin
            case (skt_pkg::t_req_type'(i_req.req_type))
                skt_pkg::REQ_INSERT: begin
                    if (w_full) begin
                        n_status = skt_pkg::ST_FULL;
                    end else begin
                        w_ctl.op = skt_pkg::OP_INSERT;
                        n_status = skt_pkg::ST_DONE;
                        n_count  = r_count + 1'b1;
                    end
                end
                skt_pkg::REQ_DELETE: begin
                    if (w_empty) begin
                        n_status = skt_pkg::ST_EMPTY;
                    end else if (!w_found) begin
                        n_status = skt_pkg::ST_NOT_FOUND;
                    end else begin
                        w_ctl.op = skt_pkg::OP_DELETE;
                        n_status = skt_pkg::ST_DONE;
                        n_count  = r_count - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Neighbour wiring; the head sees a virtual "smaller" cell, the tail an empty one
    for (genvar g = 0; g < skt_pkg::DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g] = '{valid: 1'b1, lt: 1'b1, eq: 1'b0, key: '0};
        end else begin : g_mid_prev
            assign w_prev[g] = w_state[g-1];
        end
        if (g == skt_pkg::DEPTH - 1) begin : g_tail
            assign w_next[g] = '{valid: 1'b0, lt: 1'b0, eq: 1'b0, key: '0};
        end else begin : g_mid_next
            assign w_next[g] = w_state[g+1];
        end

        skt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  (w_prev[g]),
            .i_next  (w_next[g]),
            .o_state (w_state[g])
        );
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status      <= n_status;
            r_entry_count <= skt_pkg::COUNT_W'(n_count);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = r_entry_count;

endmodule

// ===== design/skt_checker.sv =====
// Port-level checks on the sorted key table, bound to the top level.
module skt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [1:0]                  i_rsp_status,
    input logic [skt_pkg::COUNT_W-1:0] i_rsp_entry_count
);

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_entry_count))
        else $error("stalled response changed");

    // Every accepted request yields a response in the next cycle
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> i_rsp_valid)
        else $error("accepted request produced no response");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == skt_pkg::ST_FULL) |->
            i_rsp_entry_count == skt_pkg::COUNT_W'(skt_pkg::DEPTH))
        else $error("full status with wrong entry count");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == skt_pkg::ST_EMPTY) |->
            i_rsp_entry_count == '0)
        else $error("empty status with non-zero entry count");

endmodule

bind sorted_key_table_insert_delete skt_checker u_skt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_entry_count (o_rsp.entry_count)
);
